FILE: rtl/lrsgd_pkg.sv
// Shared constants, types and the sigmoid lookup table of the logistic-regression engine.
`timescale 1ns / 1ps

package lrsgd_pkg;

    localparam int FEATURE_COUNT   = 64;
    localparam int SIGMOID_ENTRIES = 256;

    localparam int CNT_W  = $clog2(FEATURE_COUNT + 1);
    localparam int W_AW   = $clog2(FEATURE_COUNT + 1);
    localparam int FB_AW  = (FEATURE_COUNT > 1) ? $clog2(FEATURE_COUNT) : 1;
    localparam int SIG_AW = (SIGMOID_ENTRIES > 1) ? $clog2(SIGMOID_ENTRIES) : 1;

    localparam int OP_W    = 2;
    localparam int IDX_W   = 7;
    localparam int WGT_W   = 32;
    localparam int FEAT_W  = 16;
    localparam int PROB_W  = 16;
    localparam int RATE_W  = 16;
    localparam int CFG_IW  = 4;
    localparam int ACC_W   = 48;
    localparam int Z_W     = 49;
    localparam int ERR_W   = 18;
    localparam int G_W     = 35;
    localparam int UPROD_W = G_W + FEAT_W;

    localparam logic [RATE_W-1:0] RATE_RESET = 16'd655;

    typedef enum logic [OP_W-1:0] {
        OP_LOAD    = 2'd0,
        OP_PREDICT = 2'd1,
        OP_TRAIN   = 2'd2,
        OP_READ    = 2'd3
    } t_op;

    typedef enum logic [CFG_IW-1:0] {
        REG_RATE_POS = 4'd0,
        REG_RATE_NEG = 4'd1
    } t_reg;

    typedef enum logic {
        KIND_SAMPLE = 1'b0,
        KIND_WEIGHT = 1'b1
    } t_kind;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic load_wr;
        logic read_issue;
        logic read_emit;
        logic feat_issue;
        logic feat_mul;
        logic feat_acc;
        logic feat_ovf;
        logic bias_issue;
        logic z_calc;
        logic sig_calc;
        logic sample_emit;
        logic upd_issue;
        logic upd_mul;
        logic upd_wr;
        logic bias_wr;
        logic clear;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        t_op  op;
        logic last;
        logic full;
        logic upd_last;
        logic cnt_zero;
    } t_status;

    typedef logic [PROB_W-1:0] t_sig_table [SIGMOID_ENTRIES];

    // Restoring division, evaluated only while the table is built.
    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [63:0]  q;
        logic [64:0]  rem;
        q   = '0;
        rem = '0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[63:0], num[b]};
            if (rem >= {1'b0, den}) begin
                rem  = rem - {1'b0, den};
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic logic [PROB_W-1:0] sig_entry(input int unsigned i);
        longint      num;
        logic        neg;
        logic [63:0] a;
        logic [63:0] q;
        logic [63:0] frac;
        longint      sum;
        logic [63:0] term;
        logic [63:0] e;
        logic [63:0] den;
        logic [63:0] s;
        num  = 16 * longint'(i) - 8 * longint'(SIGMOID_ENTRIES);
        neg  = num < 0;
        a    = neg ? 64'(-num) : 64'(num);
        q    = a / SIGMOID_ENTRIES;
        frac = ((a % SIGMOID_ENTRIES) << 32) / SIGMOID_ENTRIES;
        sum  = longint'(64'd1 << 32);
        term = 64'd1 << 32;
        for (int k = 1; k <= 24; k++) begin
            term = udiv64((term * frac) >> 32, 64'(k));
            if (k % 2 == 1) begin
                sum = sum - longint'(term);
            end else begin
                sum = sum + longint'(term);
            end
        end
        e = 64'(sum);
        for (longint k = 0; k < longint'(q); k++) begin
            e = (e * 64'd1580030169) >> 32;
        end
        den = (64'd1 << 32) + e;
        if (neg) begin
            s = udiv64((e << 16) + (den >> 1), den);
        end else begin
            s = udiv64((64'd1 << 48) + (den >> 1), den);
        end
        return (s > 64'd65535) ? 16'hFFFF : s[15:0];
    endfunction

    function automatic t_sig_table build_sig_table();
        t_sig_table t;
        for (int i = 0; i < SIGMOID_ENTRIES; i++) begin
            t[i] = sig_entry(i);
        end
        return t;
    endfunction

    localparam t_sig_table SIG_TABLE = build_sig_table();

    function automatic logic signed [WGT_W-1:0] sat32(input logic signed [35:0] v);
        if (v > 36'sh07FFFFFFF) begin
            return 32'sh7FFFFFFF;
        end else if (v < -36'sh080000000) begin
            return 32'sh80000000;
        end
        return v[WGT_W-1:0];
    endfunction

endpackage

FILE: rtl/logistic_regression_sgd.sv
// Top level of the logistic-regression inference and SGD training engine.
`timescale 1ns / 1ps

// Channel     Handshake                     Payload
// item in     i_start, accepted when !o_busy i_op, i_weight_index, i_weight_value,
//                                            i_feature_value, i_label, i_last
// result out  o_valid, one-cycle strobe      o_kind, o_probability, o_read_weight,
//                                            o_count_error
// config      i_cfg_valid / o_cfg_ready      i_cfg_index, i_cfg_data
//
// One item is in work at a time; o_busy stays high until it is done.
// A load is decoded and written; a read is decoded, issued to the weight memory
// and emitted, with the result strobed in the cycle after the emit state. A
// feature is read through the weight memory's registered read port, multiplied
// and accumulated. The item marked last adds the bias read, z, the sigmoid table
// and the result; a train sample then updates each stored weight and the bias.
// Reset is synchronous and active low; weights read as zero until written.
// Results cannot be held off by the receiver; configuration is always ready.

module logistic_regression_sgd (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    output logic                o_busy,
    input  logic [1:0]          i_op,
    input  logic [6:0]          i_weight_index,
    input  logic signed [31:0]  i_weight_value,
    input  logic signed [15:0]  i_feature_value,
    input  logic                i_label,
    input  logic                i_last,
    output logic                o_valid,
    output logic                o_kind,
    output logic [15:0]         o_probability,
    output logic signed [31:0]  o_read_weight,
    output logic                o_count_error,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [3:0]          i_cfg_index,
    input  logic [15:0]         i_cfg_data
);
    import lrsgd_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;

    // Rate registers may be written at any cycle.
    assign o_cfg_ready = 1'b1;

    lrsgd_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_start),
        .o_busy   (o_busy),
        .i_status (w_status),
        .o_cmd    (w_cmd)
    );

    lrsgd_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_status        (w_status),
        .i_op            (i_op),
        .i_weight_index  (i_weight_index),
        .i_weight_value  (i_weight_value),
        .i_feature_value (i_feature_value),
        .i_label         (i_label),
        .i_last          (i_last),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_valid         (o_valid),
        .o_kind          (o_kind),
        .o_probability   (o_probability),
        .o_read_weight   (o_read_weight),
        .o_count_error   (o_count_error)
    );

endmodule

FILE: rtl/lrsgd_ram.sv
// Generic single-port-write, registered-read memory.
`timescale 1ns / 1ps

module lrsgd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                             i_clk,
    input  logic                             i_we,
    input  logic [$clog2(DEPTH)-1:0]         i_waddr,
    input  logic [WIDTH-1:0]                 i_wdata,
    input  logic [$clog2(DEPTH)-1:0]         i_raddr,
    output logic [WIDTH-1:0]                 o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/lrsgd_dp.sv
// Datapath: weight and feature memories, dot accumulator, sigmoid lookup and SGD update.
`timescale 1ns / 1ps

module lrsgd_dp (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  lrsgd_pkg::t_cmd              i_cmd,
    output lrsgd_pkg::t_status           o_status,
    input  logic [1:0]                   i_op,
    input  logic [6:0]                   i_weight_index,
    input  logic signed [31:0]           i_weight_value,
    input  logic signed [15:0]           i_feature_value,
    input  logic                         i_label,
    input  logic                         i_last,
    input  logic                         i_cfg_valid,
    input  logic [3:0]                   i_cfg_index,
    input  logic [15:0]                  i_cfg_data,
    output logic                         o_valid,
    output logic                         o_kind,
    output logic [15:0]                  o_probability,
    output logic signed [31:0]           o_read_weight,
    output logic                         o_count_error
);
    import lrsgd_pkg::*;

    localparam logic signed [Z_W-1:0] ZHI = Z_W'(64'sd1 <<< 35);
    localparam logic signed [Z_W-1:0] ZLO = -ZHI;
    localparam int SCW = 36 + SIG_AW + 1;

    // Captured item.
    t_op                      r_op;
    logic [IDX_W-1:0]         r_idx;
    logic signed [WGT_W-1:0]  r_wval;
    logic signed [FEAT_W-1:0] r_feat;
    logic                     r_label;
    logic                     r_last;

    logic [RATE_W-1:0]        r_rate_pos;
    logic [RATE_W-1:0]        r_rate_neg;

    logic signed [ACC_W-1:0]  r_acc;
    logic [CNT_W-1:0]         r_cnt;
    logic                     r_ovf;
    logic signed [ACC_W-1:0]  r_prod;
    logic signed [Z_W-1:0]    r_z;
    logic [PROB_W-1:0]        r_prob;
    logic signed [G_W-1:0]    r_g;
    logic [CNT_W-1:0]         r_ui;
    logic signed [UPROD_W-1:0] r_uprod;
    logic signed [WGT_W-1:0]  r_uw;
    logic                     r_rvalid;
    logic [FEATURE_COUNT:0]   r_vbit;

    logic                     r_out_valid;
    logic                     r_out_kind;
    logic [PROB_W-1:0]        r_out_prob;
    logic signed [WGT_W-1:0]  r_out_rw;
    logic                     r_out_cerr;

    logic [W_AW-1:0]          w_raddr;
    logic                     w_rin_range;
    logic                     w_we;
    logic [W_AW-1:0]          w_waddr;
    logic signed [WGT_W-1:0]  w_wdata;
    logic [WGT_W-1:0]         w_rdata_raw;
    logic signed [WGT_W-1:0]  w_rd;
    logic [FEAT_W-1:0]        w_fb_rdata;
    logic                     w_idx_ok;

    logic signed [ACC_W:0]    w_acc_sum;
    logic signed [ACC_W-1:0]  w_acc_sat;
    logic [35:0]              w_zoff;
    logic [SCW-1:0]           w_scaled;
    logic [SIG_AW-1:0]        w_sig_idx;
    logic signed [ERR_W-1:0]  w_err;
    logic [RATE_W-1:0]        w_rate;
    logic signed [UPROD_W-1:0] w_urnd;
    logic signed [G_W-1:0]    w_grnd;
    logic signed [35:0]       w_usum;
    logic signed [35:0]       w_bsum;

    assign w_idx_ok = 32'(r_idx) <= FEATURE_COUNT;

    // Weight read address.
    always_comb begin
        w_raddr     = '0;
        w_rin_range = 1'b1;
        if (i_cmd.feat_issue) begin
            w_raddr = W_AW'(r_cnt);
        end else if (i_cmd.bias_issue) begin
            w_raddr = W_AW'(FEATURE_COUNT);
        end else if (i_cmd.upd_issue) begin
            w_raddr = W_AW'(r_ui);
        end else if (i_cmd.read_issue && w_idx_ok) begin
            w_raddr = W_AW'(r_idx);
        end else begin
            w_rin_range = 1'b0;
        end
    end

    assign w_urnd = r_uprod + UPROD_W'(32768);
    assign w_grnd = r_g + G_W'(128);
    assign w_usum = 36'(r_uw) + 36'(signed'(w_urnd[UPROD_W-1:16]));
    assign w_bsum = 36'(w_rd) + 36'(signed'(w_grnd[G_W-1:8]));

    // Weight write port.
    always_comb begin
        w_we    = 1'b0;
        w_waddr = '0;
        w_wdata = r_wval;
        if (i_cmd.load_wr && w_idx_ok) begin
            w_we    = 1'b1;
            w_waddr = W_AW'(r_idx);
        end else if (i_cmd.upd_wr) begin
            w_we    = 1'b1;
            w_waddr = W_AW'(r_ui);
            w_wdata = sat32(w_usum);
        end else if (i_cmd.bias_wr) begin
            w_we    = 1'b1;
            w_waddr = W_AW'(FEATURE_COUNT);
            w_wdata = sat32(w_bsum);
        end
    end

    lrsgd_ram #(.WIDTH(WGT_W), .DEPTH(FEATURE_COUNT + 1)) u_wram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata_raw)
    );

    lrsgd_ram #(.WIDTH(FEAT_W), .DEPTH(FEATURE_COUNT)) u_fram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.feat_issue),
        .i_waddr (r_cnt[FB_AW-1:0]),
        .i_wdata (r_feat),
        .i_raddr (r_ui[FB_AW-1:0]),
        .o_rdata (w_fb_rdata)
    );

    // Slots never written read as zero.
    assign w_rd = r_rvalid ? signed'(w_rdata_raw) : '0;

    assign w_acc_sum = (ACC_W + 1)'(r_acc) + (ACC_W + 1)'(r_prod);
    always_comb begin
        if (w_acc_sum[ACC_W] != w_acc_sum[ACC_W-1]) begin
            w_acc_sat = w_acc_sum[ACC_W] ? {1'b1, {(ACC_W - 1){1'b0}}}
                                         : {1'b0, {(ACC_W - 1){1'b1}}};
        end else begin
            w_acc_sat = w_acc_sum[ACC_W-1:0];
        end
    end

    // Table index from z, clamped to the table's range.
    assign w_zoff   = 36'(r_z + ZHI);
    assign w_scaled = SCW'(w_zoff) * SCW'(SIGMOID_ENTRIES);
    always_comb begin
        if (r_z < ZLO) begin
            w_sig_idx = '0;
        end else if (r_z >= ZHI) begin
            w_sig_idx = SIG_AW'(SIGMOID_ENTRIES - 1);
        end else begin
            w_sig_idx = w_scaled[36 +: SIG_AW];
        end
    end

    assign w_err  = (r_label ? ERR_W'(65536) : '0) - ERR_W'(r_prob);
    assign w_rate = r_label ? r_rate_pos : r_rate_neg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate_pos  <= RATE_RESET;
            r_rate_neg  <= RATE_RESET;
            r_acc       <= '0;
            r_cnt       <= '0;
            r_ovf       <= 1'b0;
            r_ui        <= '0;
            r_vbit      <= '0;
            r_out_valid <= 1'b0;
            r_op        <= OP_LOAD;
            r_last      <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    REG_RATE_POS: r_rate_pos <= i_cfg_data;
                    REG_RATE_NEG: r_rate_neg <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.capture) begin
                r_op   <= t_op'(i_op);
                r_last <= i_last;
            end
            if (w_we) begin
                r_vbit[w_waddr] <= 1'b1;
            end
            if (i_cmd.feat_acc) begin
                r_acc <= w_acc_sat;
                r_cnt <= r_cnt + 1'b1;
            end
            if (i_cmd.feat_ovf) begin
                r_ovf <= 1'b1;
            end
            if (i_cmd.sample_emit) begin
                r_ui <= '0;
            end else if (i_cmd.upd_wr) begin
                r_ui <= r_ui + 1'b1;
            end
            if (i_cmd.clear) begin
                r_acc <= '0;
                r_cnt <= '0;
                r_ovf <= 1'b0;
            end
            r_out_valid <= i_cmd.read_emit | i_cmd.sample_emit;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_idx   <= i_weight_index;
            r_wval  <= i_weight_value;
            r_feat  <= i_feature_value;
            r_label <= i_label;
        end
        r_rvalid <= w_rin_range && r_vbit[w_raddr];
        if (i_cmd.feat_mul) begin
            r_prod <= ACC_W'(w_rd * r_feat);
        end
        if (i_cmd.z_calc) begin
            r_z <= Z_W'(r_acc) + (Z_W'(w_rd) <<< 8);
        end
        if (i_cmd.sig_calc) begin
            r_prob <= SIG_TABLE[w_sig_idx];
        end
        if (i_cmd.sample_emit) begin
            r_g <= G_W'(signed'({1'b0, w_rate}) * w_err);
        end
        if (i_cmd.upd_mul) begin
            r_uprod <= UPROD_W'(r_g * signed'(w_fb_rdata));
            r_uw    <= w_rd;
        end
        if (i_cmd.read_emit) begin
            r_out_kind <= KIND_WEIGHT;
            r_out_prob <= '0;
            r_out_rw   <= w_rd;
            r_out_cerr <= 1'b0;
        end else if (i_cmd.sample_emit) begin
            r_out_kind <= KIND_SAMPLE;
            r_out_prob <= r_prob;
            r_out_rw   <= '0;
            r_out_cerr <= r_ovf || (32'(r_cnt) != FEATURE_COUNT);
        end
    end

    assign o_status.op       = r_op;
    assign o_status.last     = r_last;
    assign o_status.full     = 32'(r_cnt) >= FEATURE_COUNT;
    assign o_status.upd_last = (r_ui == r_cnt - 1'b1);
    assign o_status.cnt_zero = (r_cnt == '0);

    assign o_valid       = r_out_valid;
    assign o_kind        = r_out_kind;
    assign o_probability = r_out_prob;
    assign o_read_weight = r_out_rw;
    assign o_count_error = r_out_cerr;

endmodule

FILE: rtl/lrsgd_ctrl.sv
// Controller state machine that sequences the datapath for every item.
`timescale 1ns / 1ps

module lrsgd_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    output logic                 o_busy,
    input  lrsgd_pkg::t_status   i_status,
    output lrsgd_pkg::t_cmd      o_cmd
);
    import lrsgd_pkg::*;

    typedef enum logic [16:0] {
        S_IDLE  = 17'h00001,
        S_DEC   = 17'h00002,
        S_LOAD  = 17'h00004,
        S_RD    = 17'h00008,
        S_RDOUT = 17'h00010,
        S_FRD   = 17'h00020,
        S_FMUL  = 17'h00040,
        S_FACC  = 17'h00080,
        S_BRD   = 17'h00100,
        S_ZC    = 17'h00200,
        S_SIG   = 17'h00400,
        S_RES   = 17'h00800,
        S_URD   = 17'h01000,
        S_UMUL  = 17'h02000,
        S_UWR   = 17'h04000,
        S_BRD2  = 17'h08000,
        S_BWR   = 17'h10000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_DEC;
                end
            end
            S_DEC: begin
                unique case (i_status.op)
                    OP_LOAD: n_state = S_LOAD;
                    OP_READ: n_state = S_RD;
                    default: begin
                        if (i_status.full) begin
                            o_cmd.feat_ovf = 1'b1;
                            n_state = i_status.last ? S_BRD : S_IDLE;
                        end else begin
                            n_state = S_FRD;
                        end
                    end
                endcase
            end
            S_LOAD: begin
                o_cmd.load_wr = 1'b1;
                n_state       = S_IDLE;
            end
            S_RD: begin
                o_cmd.read_issue = 1'b1;
                n_state          = S_RDOUT;
            end
            S_RDOUT: begin
                o_cmd.read_emit = 1'b1;
                n_state         = S_IDLE;
            end
            S_FRD: begin
                o_cmd.feat_issue = 1'b1;
                n_state          = S_FMUL;
            end
            S_FMUL: begin
                o_cmd.feat_mul = 1'b1;
                n_state        = S_FACC;
            end
            S_FACC: begin
                o_cmd.feat_acc = 1'b1;
                n_state        = i_status.last ? S_BRD : S_IDLE;
            end
            S_BRD: begin
                o_cmd.bias_issue = 1'b1;
                n_state          = S_ZC;
            end
            S_ZC: begin
                o_cmd.z_calc = 1'b1;
                n_state      = S_SIG;
            end
            S_SIG: begin
                o_cmd.sig_calc = 1'b1;
                n_state        = S_RES;
            end
            S_RES: begin
                o_cmd.sample_emit = 1'b1;
                if (i_status.op == OP_TRAIN) begin
                    n_state = i_status.cnt_zero ? S_BRD2 : S_URD;
                end else begin
                    o_cmd.clear = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            S_URD: begin
                o_cmd.upd_issue = 1'b1;
                n_state         = S_UMUL;
            end
            S_UMUL: begin
                o_cmd.upd_mul = 1'b1;
                n_state       = S_UWR;
            end
            S_UWR: begin
                o_cmd.upd_wr = 1'b1;
                n_state      = i_status.upd_last ? S_BRD2 : S_URD;
            end
            S_BRD2: begin
                o_cmd.bias_issue = 1'b1;
                n_state          = S_BWR;
            end
            S_BWR: begin
                o_cmd.bias_wr = 1'b1;
                o_cmd.clear   = 1'b1;
                n_state       = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != S_IDLE);

endmodule
